### sv/snu_pkg.sv
`default_nettype none
package snu_pkg;

  // Width of one component of the raw, unnormalized normal vector.
  localparam int VW = 49;
  localparam int EPS_W = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;
  localparam int NORM_W = 16;

  typedef logic signed [VW-1:0] vcomp_t;

  typedef struct packed {
    vcomp_t x;
    vcomp_t y;
    vcomp_t z;
  } vvec_t;

endpackage
`default_nettype wire

### sv/surface_normal_unit.sv
`default_nettype none
// Surface normal unit: takes one ray hit per cycle and returns its unit normal in Q2.14,
// one result per cycle, while the output is not stalled. A six-stage front end forms the
// raw normal (sphere offset, cap or base axis, radial vector or viewer-facing plane
// normal); a small queue lets it keep accepting while the output is stalled, until the
// queue is full. The back end normalizes in 54 stages: magnitude scaling, a square root
// and a rounded division, each one bit per stage. Epsilon must be written through the cfg
// port only while the unit is idle; the unit itself does not enforce it.
module surface_normal_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [snu_pkg::EPS_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_obj_kind,
  input  logic signed [31:0]                in_hit_x,
  input  logic signed [31:0]                in_hit_y,
  input  logic signed [31:0]                in_hit_z,
  input  logic signed [31:0]                in_ref_x,
  input  logic signed [31:0]                in_ref_y,
  input  logic signed [31:0]                in_ref_z,
  input  logic signed [31:0]                in_axis_x,
  input  logic signed [31:0]                in_axis_y,
  input  logic signed [31:0]                in_axis_z,
  input  logic [30:0]                       in_obj_height,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [snu_pkg::NORM_W-1:0] out_normal_x,
  output logic signed [snu_pkg::NORM_W-1:0] out_normal_y,
  output logic signed [snu_pkg::NORM_W-1:0] out_normal_z
);
  import snu_pkg::*;

  logic [EPS_W-1:0] eps_r;
  logic             fq_valid, fq_ready, bq_valid, bq_ready;
  vvec_t            fq_vec, bq_vec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_valid) begin
      eps_r <= cfg_data;
    end
  end

  snu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_obj_kind  (in_obj_kind),
    .in_hit_x     (in_hit_x),
    .in_hit_y     (in_hit_y),
    .in_hit_z     (in_hit_z),
    .in_ref_x     (in_ref_x),
    .in_ref_y     (in_ref_y),
    .in_ref_z     (in_ref_z),
    .in_axis_x    (in_axis_x),
    .in_axis_y    (in_axis_y),
    .in_axis_z    (in_axis_z),
    .in_obj_height(in_obj_height),
    .eps          (eps_r),
    .q_valid      (fq_valid),
    .q_ready      (fq_ready),
    .q_vec        (fq_vec)
  );

  snu_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(fq_valid),
    .wr_ready(fq_ready),
    .wr_data (fq_vec),
    .rd_valid(bq_valid),
    .rd_ready(bq_ready),
    .rd_data (bq_vec)
  );

  snu_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (bq_valid),
    .q_ready     (bq_ready),
    .q_vec       (bq_vec),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_normal_x(out_normal_x),
    .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z)
  );

endmodule
`default_nettype wire

### sv/snu_front.sv
`default_nettype none
module snu_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_obj_kind,
  input  logic signed [31:0]        in_hit_x,
  input  logic signed [31:0]        in_hit_y,
  input  logic signed [31:0]        in_hit_z,
  input  logic signed [31:0]        in_ref_x,
  input  logic signed [31:0]        in_ref_y,
  input  logic signed [31:0]        in_ref_z,
  input  logic signed [31:0]        in_axis_x,
  input  logic signed [31:0]        in_axis_y,
  input  logic signed [31:0]        in_axis_z,
  input  logic [30:0]               in_obj_height,
  input  logic [snu_pkg::EPS_W-1:0] eps,
  output logic                      q_valid,
  input  logic                      q_ready,
  output snu_pkg::vvec_t            q_vec
);
  import snu_pkg::*;

  localparam logic [1:0] KIND_SPHERE = 2'd0;
  localparam logic [1:0] KIND_CONE   = 2'd1;
  localparam logic [1:0] KIND_CYL    = 2'd2;
  localparam logic [1:0] KIND_PLANE  = 2'd3;

  typedef enum logic [1:0] {SEL_SPHERE, SEL_POS_AXIS, SEL_NEG_AXIS, SEL_RADIAL} sel_t;

  logic signed [31:0] hit [3];
  logic signed [31:0] rf [3];
  logic signed [31:0] ax [3];

  assign hit[0] = in_hit_x;
  assign hit[1] = in_hit_y;
  assign hit[2] = in_hit_z;
  assign rf[0]  = in_ref_x;
  assign rf[1]  = in_ref_y;
  assign rf[2]  = in_ref_z;
  assign ax[0]  = in_axis_x;
  assign ax[1]  = in_axis_y;
  assign ax[2]  = in_axis_z;

  logic [5:0] fv_r, fv_nxt;
  logic       en_f;

  // Stage 1
  logic [1:0]         kind1_r;
  logic [30:0]        h1_r;
  logic signed [31:0] ax1_r [3];
  logic signed [31:0] d1_r [3], d1_nxt [3];
  logic signed [32:0] sv1_r [3], sv1_nxt [3];
  logic signed [63:0] pr1_r [3], pr1_nxt [3];
  // Stage 2
  logic [1:0]         kind2_r;
  logic [30:0]        h2_r;
  logic signed [31:0] ax2_r [3];
  logic signed [31:0] d2_r [3];
  logic signed [32:0] sv2_r [3];
  logic signed [63:0] prod2_r [3], prod2_nxt [3];
  logic               flip2_r, flip2_nxt;
  logic signed [49:0] psum;
  // Stage 3
  logic [1:0]         kind3_r;
  logic [30:0]        h3_r;
  logic signed [31:0] ax3_r [3];
  logic signed [31:0] d3_r [3];
  logic signed [32:0] sv3_r [3];
  logic               flip3_r;
  logic signed [49:0] p3_r, p3_nxt;
  // Stage 4
  sel_t               sel4_r, sel4_nxt;
  logic signed [31:0] ps4_r, ps4_nxt;
  logic signed [31:0] ax4_r [3];
  logic signed [31:0] d4_r [3];
  logic signed [32:0] sv4_r [3];
  logic signed [52:0] p_ext, h_ext;
  logic [52:0]        eps2;
  logic               top_hit, bot_hit, base_hit;
  // Stage 5
  sel_t               sel5_r;
  logic signed [31:0] ax5_r [3];
  logic signed [31:0] d5_r [3];
  logic signed [32:0] sv5_r [3];
  logic signed [63:0] m5_r [3], m5_nxt [3];
  // Stage 6
  vcomp_t             v6_r [3], v6_nxt [3];

  function automatic logic [52:0] mag53(input logic signed [52:0] t);
    return t[52] ? 53'(-t) : 53'(t);
  endfunction

  assign en_f     = !fv_r[5] || q_ready;
  assign in_ready = en_f;
  assign fv_nxt   = {fv_r[4:0], in_valid};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sv1_nxt[i] = 33'(hit[i]) - 33'(rf[i]);
      if (sv1_nxt[i][32] != sv1_nxt[i][31]) begin
        d1_nxt[i] = sv1_nxt[i][32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        d1_nxt[i] = sv1_nxt[i][31:0];
      end
      pr1_nxt[i] = 64'(rf[i]) * 64'(ax[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod2_nxt[i] = 64'(d1_r[i]) * 64'(ax1_r[i]);
    end
    psum = 50'(pr1_r[0] >>> 16) + 50'(pr1_r[1] >>> 16) + 50'(pr1_r[2] >>> 16);
    flip2_nxt = psum > 50'sd0;
  end

  assign p3_nxt = 50'(prod2_r[0] >>> 16) + 50'(prod2_r[1] >>> 16) + 50'(prod2_r[2] >>> 16);

  // Cap tests are done on doubled values so that half the height stays exact; the base test is not.
  always_comb begin
    p_ext    = 53'(p3_r);
    h_ext    = $signed({22'd0, h3_r});
    eps2     = {36'd0, eps, 1'b0};
    top_hit  = mag53((p_ext <<< 1) - h_ext) < eps2;
    bot_hit  = mag53((p_ext <<< 1) + h_ext) < eps2;
    base_hit = mag53(p_ext - h_ext) < {37'd0, eps};
    unique case (kind3_r)
      KIND_SPHERE: sel4_nxt = SEL_SPHERE;
      KIND_PLANE:  sel4_nxt = flip3_r ? SEL_NEG_AXIS : SEL_POS_AXIS;
      KIND_CYL: begin
        priority if (top_hit) sel4_nxt = SEL_POS_AXIS;
        else if (bot_hit)     sel4_nxt = SEL_NEG_AXIS;
        else                  sel4_nxt = SEL_RADIAL;
      end
      KIND_CONE:   sel4_nxt = base_hit ? SEL_NEG_AXIS : SEL_RADIAL;
      default:     sel4_nxt = SEL_RADIAL;
    endcase
    if (p3_r[49:31] != {19{p3_r[49]}}) begin
      ps4_nxt = p3_r[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      ps4_nxt = p3_r[31:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m5_nxt[i] = 64'(ax4_r[i]) * 64'(ps4_r);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (sel5_r)
        SEL_SPHERE:   v6_nxt[i] = VW'(sv5_r[i]);
        SEL_POS_AXIS: v6_nxt[i] = VW'(ax5_r[i]);
        SEL_NEG_AXIS: v6_nxt[i] = -VW'(ax5_r[i]);
        SEL_RADIAL:   v6_nxt[i] = VW'(d5_r[i]) - VW'(m5_r[i] >>> 16);
        default:      v6_nxt[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en_f) begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      kind1_r <= in_obj_kind;
      h1_r    <= in_obj_height;
      kind2_r <= kind1_r;
      h2_r    <= h1_r;
      flip2_r <= flip2_nxt;
      kind3_r <= kind2_r;
      h3_r    <= h2_r;
      flip3_r <= flip2_r;
      p3_r    <= p3_nxt;
      sel4_r  <= sel4_nxt;
      ps4_r   <= ps4_nxt;
      sel5_r  <= sel4_r;
      for (int i = 0; i < 3; i++) begin
        ax1_r[i]   <= ax[i];
        d1_r[i]    <= d1_nxt[i];
        sv1_r[i]   <= sv1_nxt[i];
        pr1_r[i]   <= pr1_nxt[i];
        ax2_r[i]   <= ax1_r[i];
        d2_r[i]    <= d1_r[i];
        sv2_r[i]   <= sv1_r[i];
        prod2_r[i] <= prod2_nxt[i];
        ax3_r[i]   <= ax2_r[i];
        d3_r[i]    <= d2_r[i];
        sv3_r[i]   <= sv2_r[i];
        ax4_r[i]   <= ax3_r[i];
        d4_r[i]    <= d3_r[i];
        sv4_r[i]   <= sv3_r[i];
        ax5_r[i]   <= ax4_r[i];
        d5_r[i]    <= d4_r[i];
        sv5_r[i]   <= sv4_r[i];
        m5_r[i]    <= m5_nxt[i];
        v6_r[i]    <= v6_nxt[i];
      end
    end
  end

  assign q_valid = fv_r[5];
  assign q_vec   = '{x: v6_r[0], y: v6_r[1], z: v6_r[2]};

endmodule
`default_nettype wire

### sv/snu_fifo.sv
`default_nettype none
module snu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  snu_pkg::vvec_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output snu_pkg::vvec_t rd_data
);
  import snu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vvec_t          mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           push, pop;

  assign wr_ready = count_r != CW'(DEPTH);
  assign rd_valid = count_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

### sv/snu_back.sv
`default_nettype none
module snu_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_ready,
  input  snu_pkg::vvec_t                    q_vec,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [snu_pkg::NORM_W-1:0] out_normal_x,
  output logic signed [snu_pkg::NORM_W-1:0] out_normal_y,
  output logic signed [snu_pkg::NORM_W-1:0] out_normal_z
);
  import snu_pkg::*;

  localparam int MW     = 48;
  localparam int SQ_N   = 31;
  localparam int DV_N   = 15;
  localparam int STAGES = 5 + (SQ_N + 1) + (DV_N + 1) + 1;

  typedef struct packed {
    logic [2:0][29:0] u;
    logic [2:0]       neg;
    logic             zero;
    logic [61:0]      rem;
    logic [30:0]      root;
  } sq_t;

  typedef struct packed {
    logic [2:0]       neg;
    logic             zero;
    logic [30:0]      len;
    logic [2:0][44:0] rem;
    logic [2:0][14:0] q;
  } dv_t;

  logic [STAGES-1:0] bv_r;
  logic              en_b;

  vcomp_t       vin [3];
  logic [MW-1:0] u1_r [3], u1_nxt [3];
  logic [2:0]    neg1_r;
  logic [MW-1:0] or1_r;

  logic [MW-1:0] u2_r [3];
  logic [2:0]    neg2_r;
  logic          zero2_r;
  logic [5:0]    nz2_r, nz2_nxt;
  logic [2:0]    loc2_r [6], loc2_nxt [6];

  logic [MW-1:0] u3_r [3];
  logic [2:0]    neg3_r;
  logic          zero3_r;
  logic [5:0]    pos3_r, pos3_nxt;

  logic [29:0]   u4_r [3], u4_nxt [3];
  logic [2:0]    neg4_r;
  logic          zero4_r;

  logic [29:0]   u5_r [3];
  logic [59:0]   sq5_r [3], sq5_nxt [3];
  logic [2:0]    neg5_r;
  logic          zero5_r;

  sq_t           sq_r [SQ_N + 1], sq_nxt [SQ_N + 1];
  dv_t           dv_r [DV_N + 1], dv_nxt [DV_N + 1];
  logic [62:0]   trial;
  logic [45:0]   den;

  logic signed [NORM_W-1:0] nrm_r [3], nrm_nxt [3];

  assign en_b    = !bv_r[STAGES-1] || out_ready;
  assign q_ready = en_b;

  assign vin[0] = q_vec.x;
  assign vin[1] = q_vec.y;
  assign vin[2] = q_vec.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u1_nxt[i] = vin[i][VW-1] ? MW'(-vin[i]) : MW'(vin[i]);
    end
  end

  // Leading-one search of the OR of all magnitudes, split over two stages.
  always_comb begin
    for (int c = 0; c < 6; c++) begin
      nz2_nxt[c]  = |or1_r[c*8 +: 8];
      loc2_nxt[c] = '0;
      for (int j = 0; j < 8; j++) begin
        if (or1_r[c*8 + j]) loc2_nxt[c] = 3'(j);
      end
    end
  end

  always_comb begin
    pos3_nxt = '0;
    for (int c = 0; c < 6; c++) begin
      if (nz2_r[c]) pos3_nxt = {3'(c), loc2_r[c]};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos3_r >= 6'd29) begin
        u4_nxt[i] = 30'(u3_r[i] >> (pos3_r - 6'd29));
      end else begin
        u4_nxt[i] = 30'(u3_r[i] << (6'd29 - pos3_r));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq5_nxt[i] = 60'(u4_r[i]) * 60'(u4_r[i]);
    end
  end

  // Square root, one result bit per stage, then rounded division, one quotient bit per stage.
  always_comb begin
    trial = '0;
    den   = '0;
    sq_nxt[0].u    = {u5_r[2], u5_r[1], u5_r[0]};
    sq_nxt[0].neg  = neg5_r;
    sq_nxt[0].zero = zero5_r;
    sq_nxt[0].rem  = 62'(sq5_r[0]) + 62'(sq5_r[1]) + 62'(sq5_r[2]);
    sq_nxt[0].root = '0;
    for (int j = 1; j <= SQ_N; j++) begin
      sq_nxt[j] = sq_r[j-1];
      trial = ({32'd0, sq_r[j-1].root} << (SQ_N - j + 1)) + (63'd1 << (2 * (SQ_N - j)));
      if (trial <= {1'b0, sq_r[j-1].rem}) begin
        sq_nxt[j].rem  = 62'({1'b0, sq_r[j-1].rem} - trial);
        sq_nxt[j].root = sq_r[j-1].root | (31'd1 << (SQ_N - j));
      end
    end

    dv_nxt[0].neg  = sq_r[SQ_N].neg;
    dv_nxt[0].zero = sq_r[SQ_N].zero;
    dv_nxt[0].len  = sq_r[SQ_N].root;
    dv_nxt[0].q    = '0;
    for (int i = 0; i < 3; i++) begin
      dv_nxt[0].rem[i] = {sq_r[SQ_N].u[i], 15'd0} >> 1;
      dv_nxt[0].rem[i] = dv_nxt[0].rem[i] + 45'(sq_r[SQ_N].root >> 1);
    end
    for (int j = 1; j <= DV_N; j++) begin
      dv_nxt[j] = dv_r[j-1];
      den = 46'(dv_r[j-1].len) << (DV_N - j);
      for (int i = 0; i < 3; i++) begin
        if ({1'b0, dv_r[j-1].rem[i]} >= den) begin
          dv_nxt[j].rem[i]         = 45'({1'b0, dv_r[j-1].rem[i]} - den);
          dv_nxt[j].q[i][DV_N - j] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_r[DV_N].zero) begin
        nrm_nxt[i] = '0;
      end else if (dv_r[DV_N].neg[i]) begin
        nrm_nxt[i] = -NORM_W'(dv_r[DV_N].q[i]);
      end else begin
        nrm_nxt[i] = NORM_W'(dv_r[DV_N].q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r <= '0;
    end else if (en_b) begin
      bv_r <= {bv_r[STAGES-2:0], q_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      or1_r   <= u1_nxt[0] | u1_nxt[1] | u1_nxt[2];
      neg1_r  <= {vin[2][VW-1], vin[1][VW-1], vin[0][VW-1]};
      neg2_r  <= neg1_r;
      zero2_r <= or1_r == '0;
      nz2_r   <= nz2_nxt;
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
      pos3_r  <= pos3_nxt;
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
      neg5_r  <= neg4_r;
      zero5_r <= zero4_r;
      for (int c = 0; c < 6; c++) begin
        loc2_r[c] <= loc2_nxt[c];
      end
      for (int i = 0; i < 3; i++) begin
        u1_r[i]  <= u1_nxt[i];
        u2_r[i]  <= u1_r[i];
        u3_r[i]  <= u2_r[i];
        u4_r[i]  <= u4_nxt[i];
        u5_r[i]  <= u4_r[i];
        sq5_r[i] <= sq5_nxt[i];
        nrm_r[i] <= nrm_nxt[i];
      end
      for (int j = 0; j <= SQ_N; j++) begin
        sq_r[j] <= sq_nxt[j];
      end
      for (int j = 0; j <= DV_N; j++) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  assign out_valid    = bv_r[STAGES-1];
  assign out_normal_x = nrm_r[0];
  assign out_normal_y = nrm_r[1];
  assign out_normal_z = nrm_r[2];

endmodule
`default_nettype wire

### tb/surface_normal_unit_test.sv
`timescale 1ns / 100ps
`default_nettype none
module surface_normal_unit_test;
  import snu_pkg::*;

  localparam logic [1:0] KIND_SPHERE = 2'd0;
  localparam logic [1:0] KIND_CONE = 2'd1;
  localparam logic [1:0] KIND_CYL = 2'd2;
  localparam logic [1:0] KIND_PLANE = 2'd3;
  localparam int LATENCY = 80;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct {
    logic [1:0] kind;
    logic signed [31:0] hit [3];
    logic signed [31:0] rf [3];
    logic signed [31:0] ax [3];
    logic [30:0] height;
  } hit_t;

  typedef struct {
    logic signed [15:0] n [3];
  } normal_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [EPS_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_obj_kind = '0;
  logic signed [31:0] in_hit_x = '0, in_hit_y = '0, in_hit_z = '0;
  logic signed [31:0] in_ref_x = '0, in_ref_y = '0, in_ref_z = '0;
  logic signed [31:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic [30:0] in_obj_height = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [NORM_W-1:0] out_normal_x, out_normal_y, out_normal_z;

  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  surface_normal_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_obj_kind(in_obj_kind),
    .in_hit_x(in_hit_x), .in_hit_y(in_hit_y), .in_hit_z(in_hit_z),
    .in_ref_x(in_ref_x), .in_ref_y(in_ref_y), .in_ref_z(in_ref_z),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_obj_height(in_obj_height),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z)
  );

  function automatic void report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endfunction

  class normal_scoreboard;
    logic [15:0] eps;
    normal_t pending[$];

    function new();
      eps = EPS_RESET;
    endfunction

    static function longint floor_q16(longint p);
      return p >>> 16;
    endfunction

    static function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    static function longint dot_q16(longint a [3], longint b [3]);
      longint s;
      s = 0;
      for (int i = 0; i < 3; i++) s += floor_q16(a[i] * b[i]);
      return s;
    endfunction

    static function longint unsigned root_floor(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b >>= 2;
      while (b != 0) begin
        if (s >= r + b) begin
          s -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    static function normal_t unit_vector(longint v [3]);
      normal_t res;
      longint unsigned u [3];
      longint unsigned m, s, len, q;
      m = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        u[i] = v[i] < 0 ? -v[i] : v[i];
        if (u[i] > m) m = u[i];
      end
      if (m == 0) begin
        for (int i = 0; i < 3; i++) res.n[i] = '0;
        return res;
      end
      while (m < (64'd1 << 29)) begin
        m <<= 1;
        for (int i = 0; i < 3; i++) u[i] <<= 1;
      end
      while (m >= (64'd1 << 30)) begin
        m >>= 1;
        for (int i = 0; i < 3; i++) u[i] >>= 1;
      end
      for (int i = 0; i < 3; i++) s += u[i] * u[i];
      len = root_floor(s);
      for (int i = 0; i < 3; i++) begin
        q = (u[i] * 16384 + len / 2) / len;
        if (v[i] < 0) q = -q;
        res.n[i] = q[15:0];
      end
      return res;
    endfunction

    function void note_hit(hit_t h);
      longint hp [3], rp [3], ap [3], d [3], v [3];
      longint p, ps, ht, e;
      ht = h.height;
      e = eps;
      for (int i = 0; i < 3; i++) begin
        hp[i] = h.hit[i];
        rp[i] = h.rf[i];
        ap[i] = h.ax[i];
      end
      if (h.kind == KIND_SPHERE) begin
        for (int i = 0; i < 3; i++) v[i] = hp[i] - rp[i];
      end else if (h.kind == KIND_PLANE) begin
        p = dot_q16(rp, ap);
        for (int i = 0; i < 3; i++) v[i] = p > 0 ? -ap[i] : ap[i];
      end else begin
        for (int i = 0; i < 3; i++) d[i] = clamp32(hp[i] - rp[i]);
        p = dot_q16(d, ap);
        if (h.kind == KIND_CYL && (2*p - ht < 0 ? ht - 2*p : 2*p - ht) < 2*e) begin
          for (int i = 0; i < 3; i++) v[i] = ap[i];
        end else if (h.kind == KIND_CYL &&
                     (2*p + ht < 0 ? -(2*p + ht) : 2*p + ht) < 2*e) begin
          for (int i = 0; i < 3; i++) v[i] = -ap[i];
        end else if (h.kind == KIND_CONE && (p - ht < 0 ? ht - p : p - ht) < e) begin
          for (int i = 0; i < 3; i++) v[i] = -ap[i];
        end else begin
          ps = clamp32(p);
          for (int i = 0; i < 3; i++) v[i] = d[i] - floor_q16(ap[i] * ps);
        end
      end
      pending.push_back(unit_vector(v));
    endfunction

    function void check_normal(logic signed [15:0] nx, logic signed [15:0] ny,
                               logic signed [15:0] nz);
      normal_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with no hit outstanding");
        return;
      end
      want = pending.pop_front();
      if (nx !== want.n[0])
        report_mismatch($sformatf("normal_x got %0d want %0d", nx, want.n[0]));
      if (ny !== want.n[1])
        report_mismatch($sformatf("normal_y got %0d want %0d", ny, want.n[1]));
      if (nz !== want.n[2])
        report_mismatch($sformatf("normal_z got %0d want %0d", nz, want.n[2]));
    endfunction
  endclass

  normal_scoreboard sb = new();

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL surface_normal_unit");
      $finish;
    end
  end

  // Output side: check on each transfer, then pick the next ready level.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_normal(out_normal_x, out_normal_y, out_normal_z);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Valid stays high from one transfer into the next unless the sender idles.
  task automatic send_hit(input hit_t h);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_obj_kind <= h.kind;
    in_hit_x <= h.hit[0]; in_hit_y <= h.hit[1]; in_hit_z <= h.hit[2];
    in_ref_x <= h.rf[0]; in_ref_y <= h.rf[1]; in_ref_z <= h.rf[2];
    in_axis_x <= h.ax[0]; in_axis_y <= h.ax[1]; in_axis_z <= h.ax[2];
    in_obj_height <= h.height;
    do @(posedge clk); while (!in_ready);
    sb.note_hit(h);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_epsilon(input logic [15:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.eps = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(65536 * 4)) - 32'sd131072;
      3: return 32'sd0;
      default: return $signed($urandom) >>> $urandom_range(20);
    endcase
  endfunction

  function automatic hit_t rand_hit();
    hit_t h;
    int unsigned pick;
    h.kind = 2'($urandom_range(3));
    for (int i = 0; i < 3; i++) begin
      h.hit[i] = rand_coord();
      h.rf[i] = rand_coord();
      h.ax[i] = $urandom_range(3) == 0 ? rand_coord() : 32'sd0;
    end
    // Mostly unit axes along one coordinate, so caps and bases can be hit.
    pick = $urandom_range(2);
    if (h.ax[pick] == 0) h.ax[pick] = $urandom_range(1) ? 32'sd65536 : -32'sd65536;
    h.height = $urandom_range(3) == 0 ? 31'($urandom) : 31'($urandom_range(1 << 22));
    if (h.kind != KIND_SPHERE && h.kind != KIND_PLANE && $urandom_range(1)) begin
      // Place the hit near a cap or base of an axis-aligned body.
      for (int i = 0; i < 3; i++) h.ax[i] = 0;
      h.ax[pick] = 32'sd65536;
      h.rf[pick] = $signed($urandom_range(1 << 20));
      h.hit[pick] = h.rf[pick] + (h.kind == KIND_CONE ? $signed({1'b0, h.height}) :
                    ($urandom_range(1) ? 1 : -1) * $signed({1'b0, h.height}) / 2)
                    + $signed($urandom_range(40)) - 32'sd20;
    end
    return h;
  endfunction

  function automatic hit_t make_hit(input logic [1:0] k, input int hx, input int hy,
                                    input int hz, input int rx, input int ry,
                                    input int rz, input int ax, input int ay,
                                    input int az, input logic [30:0] ht);
    hit_t h;
    h.kind = k;
    h.hit[0] = hx; h.hit[1] = hy; h.hit[2] = hz;
    h.rf[0] = rx; h.rf[1] = ry; h.rf[2] = rz;
    h.ax[0] = ax; h.ax[1] = ay; h.ax[2] = az;
    h.height = ht;
    return h;
  endfunction

  task automatic random_phase(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) send_hit(rand_hit());
  endtask

  localparam int ONE = 65536;
  localparam int MAXI = 32'h7fffffff;
  localparam int MINI = 32'h80000000;

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // Directed hits.
    send_hit(make_hit(KIND_SPHERE, ONE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_hit(make_hit(KIND_SPHERE, 5, 5, 5, 5, 5, 5, 0, 0, 0, 0));
    send_hit(make_hit(KIND_SPHERE, MAXI, MAXI, MAXI, MINI, MINI, MINI, 0, 0, 0, 0));
    send_hit(make_hit(KIND_SPHERE, MINI, 3, MAXI, MAXI, -7, MINI, 0, 0, 0, 31'h7fffffff));
    send_hit(make_hit(KIND_PLANE, 0, 0, 0, ONE, 0, 0, ONE, 0, 0, 0));
    send_hit(make_hit(KIND_PLANE, 0, 0, 0, ONE, 0, 0, -ONE, 0, 0, 0));
    send_hit(make_hit(KIND_PLANE, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0));
    send_hit(make_hit(KIND_PLANE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_hit(make_hit(KIND_PLANE, 0, 0, 0, MINI, MAXI, 0, MINI, MAXI, MINI, 0));
    send_hit(make_hit(KIND_CYL, 0, 0, ONE, 0, 0, 0, 0, 0, ONE, 2 * ONE));
    send_hit(make_hit(KIND_CYL, 0, 0, -ONE, 0, 0, 0, 0, 0, ONE, 2 * ONE));
    send_hit(make_hit(KIND_CYL, ONE, 0, 0, 0, 0, 0, 0, 0, ONE, 2 * ONE));
    send_hit(make_hit(KIND_CYL, 0, 0, ONE + 7, 0, 0, 0, 0, 0, ONE, 2 * ONE));
    send_hit(make_hit(KIND_CYL, 0, 0, ONE + 6, 0, 0, 0, 0, 0, ONE, 2 * ONE));
    send_hit(make_hit(KIND_CYL, MAXI, 0, 0, MINI, 0, 0, MAXI, MAXI, 0, 31'h7fffffff));
    send_hit(make_hit(KIND_CONE, 0, 0, 3 * ONE, 0, 0, 0, 0, 0, ONE, 3 * ONE));
    send_hit(make_hit(KIND_CONE, ONE, 0, ONE, 0, 0, 0, 0, 0, ONE, 3 * ONE));
    send_hit(make_hit(KIND_CONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_hit(make_hit(KIND_CONE, 3, 1, 2, 0, 0, 0, 2 * ONE, ONE, 0, 5));
    send_hit(make_hit(KIND_CONE, MINI, MINI, MINI, MAXI, MAXI, MAXI,
                      MINI, MINI, MINI, 31'h7fffffff));
    // Sender holds off until every expected normal has come back.
    drain();
    write_epsilon(16'd0);
    random_phase(150, 0, 0);
    write_epsilon(16'hffff);
    random_phase(200, 58, 0);
    write_epsilon(16'd300);
    random_phase(200, 0, 58);
    write_epsilon(16'd1);
    random_phase(200, 12, 12);
    write_epsilon(EPS_RESET);
    random_phase(280, 0, 0);
    recv_stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("PASS surface_normal_unit");
    end else begin
      $display("FAIL surface_normal_unit");
    end
    $finish;
  end
endmodule
`default_nettype wire
